FILE: rtl/core/gbn_pkg.sv
// Shared types and constants for the go-back-N window sender.
// Used by gbn_ctrl, gbn_dp and go_back_n_window_sender; no dependencies.
`default_nettype none

package gbn_pkg;

	// event codes on opcode
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_RECV  = 2'd1;
	localparam logic [1:0] OP_TMO   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [1:0] REG_TOTAL_PKTS  = 2'd1;
	localparam logic [1:0] REG_LAST_BYTES  = 2'd2;
	localparam logic [1:0] REG_START_SEQ   = 2'd3;

	localparam logic [4:0]  WINDOW_SIZE_RST = 5'd8;
	localparam logic [31:0] START_SEQ_RST   = 32'd16000;

	// result codes
	localparam logic       KIND_SEND = 1'b0;
	localparam logic       KIND_DONE = 1'b1;
	localparam logic [1:0] PT_START  = 2'd0;
	localparam logic [1:0] PT_END    = 2'd1;
	localparam logic [1:0] PT_DATA   = 2'd2;

	// acknowledgement format
	localparam logic [4:0]  ACK_LEN  = 5'd20;
	localparam logic [31:0] ACK_TYPE = 32'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_DRAIN,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_EVAL,
		C_WIN,
		C_EMIT,
		C_ONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		ONE_START,
		ONE_END,
		ONE_DONE
	} one_sel_t;

	typedef struct packed {
		logic     load_rx;
		logic     clr_window;
		logic     set_base0;
		logic     upd_base;
		logic     win_init;
		logic     emit_data;
		logic     emit_one;
		one_sel_t one_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       seq_eq_start;
		logic       ack_ok;
		logic       win_full;
		logic       base_ge_total;
		logic       last_data;
		logic       out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/gbn_dp.sv
// Datapath of the go-back-N sender: config registers, window registers,
// received header, offset multiply and the output register. Uses gbn_pkg.
`default_nettype none

module gbn_dp import gbn_pkg::*; #(
	parameter int WINDOW_MAX  = 16,
	parameter int FRAME_BYTES = 1456
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [1:0]  opcode,
	input  wire logic [4:0]  rx_length,
	input  wire logic [31:0] rx_type,
	input  wire logic [31:0] rx_seq,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic             kind,
	output logic [1:0]       packet_type,
	output logic [31:0]      seq_number,
	output logic [10:0]      payload_bytes,
	output logic [31:0]      payload_offset,
	output logic             last,
	input  wire ctl_cmd_t    cmd,
	output dp_stat_t         stat
);

	localparam int LW = $clog2(WINDOW_MAX + 1);

	logic [4:0]    window_size_q;
	logic [31:0]   total_q;
	logic [10:0]   last_bytes_q;
	logic [31:0]   start_seq_q;

	logic [1:0]    op_q;
	logic [4:0]    rx_len_q;
	logic [31:0]   rx_type_q;
	logic [31:0]   rx_seq_q;

	logic [31:0]   base_q;
	logic [31:0]   head_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic [31:0]   cur_seq_q;
	logic [31:0]   off_q;

	logic          out_valid_q;
	logic          kind_q;
	logic [1:0]    ptype_q;
	logic [31:0]   seq_out_q;
	logic [10:0]   bytes_q;
	logic [31:0]   off_out_q;
	logic          last_q;

	logic [32:0]   head_plus_len;
	logic [31:0]   base_new;
	logic [LW-1:0] eff_win;
	logic [31:0]   left;
	logic [LW-1:0] new_len;
	logic [47:0]   prod;
	logic [10:0]   data_bytes;
	logic          is_final;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			total_q       <= '0;
			last_bytes_q  <= '0;
			start_seq_q   <= START_SEQ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE: window_size_q <= cfg_data[4:0];
				REG_TOTAL_PKTS:  total_q       <= cfg_data;
				REG_LAST_BYTES:  last_bytes_q  <= cfg_data[10:0];
				REG_START_SEQ:   start_seq_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	// received header
	always_ff @(posedge clk) begin
		if (cmd.load_rx) begin
			op_q      <= opcode;
			rx_len_q  <= rx_length;
			rx_type_q <= rx_type;
			rx_seq_q  <= rx_seq;
		end
	end

	always_comb begin
		head_plus_len = {1'b0, head_q} + 33'(len_q);
		base_new      = (rx_seq_q > base_q) ? rx_seq_q : base_q;

		// clamp window size to 1..WINDOW_MAX
		if (window_size_q == 5'd0)
			eff_win = LW'(1);
		else if (32'(window_size_q) > 32'(WINDOW_MAX))
			eff_win = LW'(WINDOW_MAX);
		else
			eff_win = LW'(window_size_q);

		left    = total_q - base_q;
		new_len = (left < 32'(eff_win)) ? LW'(left) : eff_win;
		prod    = base_q * 16'(FRAME_BYTES);

		is_final = (cur_seq_q == total_q - 32'd1) && (last_bytes_q != 11'd0);
		if (!is_final)
			data_bytes = 11'(FRAME_BYTES);
		else if (32'(last_bytes_q) > 32'(FRAME_BYTES))
			data_bytes = 11'(FRAME_BYTES);
		else
			data_bytes = last_bytes_q;
	end

	assign stat.op            = op_q;
	assign stat.seq_eq_start  = (rx_seq_q == start_seq_q);
	assign stat.ack_ok        = (rx_len_q == ACK_LEN) && (rx_type_q == ACK_TYPE)
		&& (rx_seq_q != start_seq_q) && (rx_seq_q >= head_q)
		&& ({1'b0, rx_seq_q} <= head_plus_len);
	assign stat.win_full      = ({1'b0, base_new} == head_plus_len);
	assign stat.base_ge_total = (base_q >= total_q);
	assign stat.last_data     = ((LW+1)'(cnt_q) + (LW+1)'(1) == (LW+1)'(len_q));
	assign stat.out_free      = !out_valid_q || !out_stall;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			head_q <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.clr_window) begin
				base_q <= '0;
				head_q <= '0;
				len_q  <= '0;
			end else if (cmd.set_base0) begin
				base_q <= '0;
			end else if (cmd.upd_base) begin
				base_q <= base_new;
			end else if (cmd.win_init) begin
				head_q <= base_q;
				len_q  <= (base_q >= total_q) ? '0 : new_len;
			end
			if (cmd.win_init)
				cnt_q <= '0;
			else if (cmd.emit_data)
				cnt_q <= cnt_q + LW'(1);
		end
	end

	// running sequence number and byte offset
	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			cur_seq_q <= base_q;
			off_q     <= prod[31:0];
		end else if (cmd.emit_data) begin
			cur_seq_q <= cur_seq_q + 32'd1;
			off_q     <= off_q + 32'(FRAME_BYTES);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_data || cmd.emit_one)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_data) begin
			kind_q    <= KIND_SEND;
			ptype_q   <= PT_DATA;
			seq_out_q <= cur_seq_q;
			bytes_q   <= data_bytes;
			off_out_q <= off_q;
			last_q    <= stat.last_data;
		end else if (cmd.emit_one) begin
			bytes_q   <= '0;
			off_out_q <= '0;
			last_q    <= 1'b1;
			case (cmd.one_sel)
				ONE_START: begin
					kind_q    <= KIND_SEND;
					ptype_q   <= PT_START;
					seq_out_q <= start_seq_q;
				end
				ONE_END: begin
					kind_q    <= KIND_SEND;
					ptype_q   <= PT_END;
					seq_out_q <= start_seq_q;
				end
				default: begin
					kind_q    <= KIND_DONE;
					ptype_q   <= PT_START;
					seq_out_q <= '0;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign packet_type    = ptype_q;
	assign seq_number     = seq_out_q;
	assign payload_bytes  = bytes_q;
	assign payload_offset = off_out_q;
	assign last           = last_q;

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_data && cmd.emit_one))
		else $error("data and single result issued together");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= 32'(WINDOW_MAX))
		else $error("window length above maximum");

	a_emit_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_data |-> (cnt_q < len_q) && (cur_seq_q < total_q))
		else $error("data packet outside the window");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_data || cmd.emit_one) |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while held");

endmodule

`default_nettype wire

FILE: rtl/core/gbn_ctrl.sv
// Controller of the go-back-N sender: protocol phase and sequencing FSM.
// Uses gbn_pkg; drives the datapath gbn_dp through ctl_cmd_t.
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);

	ctl_state_t state_q, state_d;
	phase_t     phase_q, phase_d;
	one_sel_t   sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			phase_q <= PH_IDLE;
			sel_q   <= ONE_START;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			sel_q   <= sel_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		sel_d   = sel_q;
		case (state_q)
			C_IDLE: begin
				if (in_valid)
					state_d = C_EVAL;
			end
			C_EVAL: begin
				state_d = C_IDLE;
				case (stat.op)
					OP_BEGIN: begin
						phase_d = PH_START;
						sel_d   = ONE_START;
						state_d = C_ONE;
					end
					OP_RECV: begin
						case (phase_q)
							PH_START: if (stat.seq_eq_start) state_d = C_WIN;
							PH_DATA: if (stat.ack_ok && stat.win_full) state_d = C_WIN;
							PH_END: begin
								if (stat.seq_eq_start) begin
									phase_d = PH_IDLE;
									sel_d   = ONE_DONE;
									state_d = C_ONE;
								end
							end
							default: ;
						endcase
					end
					OP_TMO: begin
						case (phase_q)
							PH_START: begin
								sel_d   = ONE_START;
								state_d = C_ONE;
							end
							PH_DATA: state_d = C_WIN;
							PH_DRAIN, PH_END: begin
								phase_d = PH_END;
								sel_d   = ONE_END;
								state_d = C_ONE;
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			C_WIN: begin
				if (stat.base_ge_total) begin
					phase_d = PH_DRAIN;
					state_d = C_IDLE;
				end else begin
					phase_d = PH_DATA;
					state_d = C_EMIT;
				end
			end
			C_EMIT: begin
				if (stat.out_free && stat.last_data)
					state_d = C_IDLE;
			end
			C_ONE: begin
				if (stat.out_free)
					state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.one_sel = sel_q;
		in_stall   = 1'b1;
		case (state_q)
			C_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_rx = in_valid;
			end
			C_EVAL: begin
				cmd.clr_window = (stat.op == OP_BEGIN);
				cmd.set_base0  = (stat.op == OP_RECV) && (phase_q == PH_START)
					&& stat.seq_eq_start;
				cmd.upd_base   = (stat.op == OP_RECV) && (phase_q == PH_DATA)
					&& stat.ack_ok;
			end
			C_WIN:  cmd.win_init  = 1'b1;
			C_EMIT: cmd.emit_data = stat.out_free;
			C_ONE:  cmd.emit_one  = stat.out_free;
			default: ;
		endcase
	end

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == C_EVAL))
		else $error("accepted request not evaluated");

	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_EMIT) |-> (phase_q == PH_DATA))
		else $error("data burst outside data phase");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != C_IDLE) |-> in_stall)
		else $error("request accepted while busy");

endmodule

`default_nettype wire

FILE: rtl/core/go_back_n_window_sender.sv
// Top level of the go-back-N window sender: controller plus datapath.
// Uses gbn_pkg, gbn_ctrl and gbn_dp.
//
//  channel   signals                                       handshake
//  --------  --------------------------------------------  ----------------
//  in        opcode, rx_length, rx_type, rx_seq            in_valid/in_stall
//  out       kind, packet_type, seq_number, payload_bytes,  out_valid/out_stall
//            payload_offset, last
//  cfg       cfg_index, cfg_data                           cfg_we, no wait
//
// One request at a time: accept, evaluate, then results. A request with no
// result ends after evaluate (after window setup if it opens an empty window
// and enters drain); one with a single result passes the single-result state;
// one sending a window passes window setup, which holds the offset multiply,
// then sends one data result per cycle from the burst state. Output stall
// holds the burst and single results; the output register keeps one result.
// Reset returns the phase to idle, clears the window and loads config defaults.
`default_nettype none

module go_back_n_window_sender import gbn_pkg::*; #(
	parameter int WINDOW_MAX  = 16,
	parameter int FRAME_BYTES = 1456
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [4:0]  rx_length,
	input  wire logic [31:0] rx_type,
	input  wire logic [31:0] rx_seq,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [1:0]       packet_type,
	output logic [31:0]      seq_number,
	output logic [10:0]      payload_bytes,
	output logic [31:0]      payload_offset,
	output logic             last
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbn_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.rx_length      (rx_length),
		.rx_type        (rx_type),
		.rx_seq         (rx_seq),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.kind           (kind),
		.packet_type    (packet_type),
		.seq_number     (seq_number),
		.payload_bytes  (payload_bytes),
		.payload_offset (payload_offset),
		.last           (last),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

`default_nettype wire
